FILE: rtl/scr_pkg.sv
// Shared types, sizes and codes of the small component remover.
package scr_pkg;

	// Largest frame the stores are sized for.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	// Derived widths.
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int PIXEL_CAP  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(PIXEL_CAP);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int QUEUE_W    = X_W + Y_W;

	// Register widths.
	localparam int DIM_W      = 9;
	localparam int MIN_W      = 17;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE     = 2'd2;

	// Register reset values.
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = 9'd256;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 9'd256;
	localparam logic [MIN_W-1:0] MIN_SIZE_RESET     = 17'd0;

	// Request operations.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	// Input request and result payloads.
	typedef struct packed {
		opcode_t opcode;
		logic    edge_in;
	} pixel_req_t;

	typedef struct packed {
		logic kept_edge;
		logic last_pixel;
	} pixel_rsp_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_DATA,
		ST_CLEAR,
		ST_SEED_RD,
		ST_SEED_CHK,
		ST_POP,
		ST_POP_WAIT,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DEL,
		ST_DEL_DRAIN,
		ST_NEXT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_wr;
		logic read_issue;
		logic out_load;
		logic clear_step;
		logic seed_rd;
		logic seed_push;
		logic seed_next;
		logic pop;
		logic latch_center;
		logic scan;
		logic del_start;
		logic del_issue;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic load_fills;
		logic seed_new;
		logic seed_last;
		logic queue_empty;
		logic comp_small;
		logic nb_last;
		logic del_done;
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/scr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module scr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/scr_ctrl.sv
// Controller state machine that sequences loads, reads and the component filter.
module scr_ctrl import scr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  opcode_t    in_opcode,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_opcode == OP_READ) begin
						cmd.read_issue = 1'b1;
						state_d        = ST_RD_DATA;
					end else begin
						cmd.load_wr = 1'b1;
						if (status.load_fills) begin
							state_d = ST_CLEAR;
						end
					end
				end
			end
			ST_RD_DATA: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.seed_last) begin
					state_d = ST_SEED_RD;
				end
			end
			ST_SEED_RD: begin
				cmd.seed_rd = 1'b1;
				state_d     = ST_SEED_CHK;
			end
			ST_SEED_CHK: begin
				if (status.seed_new) begin
					cmd.seed_push = 1'b1;
					state_d       = ST_POP;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_POP: begin
				if (status.queue_empty) begin
					if (status.comp_small) begin
						cmd.del_start = 1'b1;
						state_d       = ST_DEL;
					end else begin
						state_d = ST_NEXT;
					end
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				cmd.latch_center = 1'b1;
				state_d          = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.nb_last) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = ST_POP;
			end
			ST_DEL: begin
				if (status.del_done) begin
					state_d = ST_DEL_DRAIN;
				end else begin
					cmd.del_issue = 1'b1;
				end
			end
			ST_DEL_DRAIN: begin
				state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (status.seed_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.seed_next = 1'b1;
					state_d       = ST_SEED_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/scr_datapath.sv
// Datapath: configuration, counters, pixel stores, search queue and neighbor pipeline.
module scr_datapath import scr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  pixel_req_t            in_req,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pixel_rsp_t            out_rsp
);

	// Configuration registers.
	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [MIN_W-1:0] min_size_q;

	// Frame counters.
	logic [CNT_W-1:0]  load_count_q;
	logic [ADDR_W-1:0] read_count_q;
	logic              last_q;

	// Search registers.
	logic [ADDR_W-1:0] seed_q;
	logic [X_W-1:0]    sx_q, cx_q;
	logic [Y_W-1:0]    sy_q, cy_q;
	logic [CNT_W-1:0]  head_q, tail_q, del_q;
	logic [1:0]        ix_q, iy_q;

	// Neighbor pipeline.
	logic              s1_valid, s2_valid;
	logic [ADDR_W-1:0] q_s1, q_s2;
	logic [X_W-1:0]    tx_s1, tx_s2;
	logic [Y_W-1:0]    ty_s1, ty_s2;

	// Deletion pipeline.
	logic              d1_valid, d2_valid;
	logic [ADDR_W-1:0] idx_d2;

	// Output register.
	logic       out_valid_q;
	pixel_rsp_t out_rsp_q;

	// Memory ports.
	logic               frm_we, frm_re, frm_wdata, frm_rdata;
	logic [ADDR_W-1:0]  frm_waddr, frm_raddr;
	logic               vis_we, vis_re, vis_wdata, vis_rdata;
	logic [ADDR_W-1:0]  vis_waddr, vis_raddr;
	logic               que_we, que_re;
	logic [ADDR_W-1:0]  que_waddr, que_raddr;
	logic [QUEUE_W-1:0] que_wdata, que_rdata;

	// Combinational values.
	logic [DIM_W-1:0]  eff_w, eff_h;
	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  ld_base;
	logic [ADDR_W-1:0] rd_idx;
	logic              rd_last;
	logic [DIM_W-1:0]  tx_full, ty_full;
	logic              nb_ok;
	logic [ADDR_W-1:0] q_s0;
	logic              nb_mark;
	logic [X_W-1:0]    qx;
	logic [Y_W-1:0]    qy;
	logic [ADDR_W-1:0] del_idx;
	logic              sx_wrap;

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
			min_size_q     <= MIN_SIZE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				CFG_MIN_SIZE:     min_size_q     <= cfg_data[MIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective frame size: zero acts as one, oversize saturates.
	always_comb begin
		if (frame_width_q == '0) begin
			eff_w = DIM_W'(1);
		end else if (frame_width_q > DIM_W'(MAX_WIDTH)) begin
			eff_w = DIM_W'(MAX_WIDTH);
		end else begin
			eff_w = frame_width_q;
		end
		if (frame_height_q == '0) begin
			eff_h = DIM_W'(1);
		end else if (frame_height_q > DIM_W'(MAX_HEIGHT)) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = frame_height_q;
		end
		total = CNT_W'(eff_w) * CNT_W'(eff_h);
	end

	// Load and read indexes.
	always_comb begin
		ld_base = (load_count_q >= total) ? '0 : load_count_q;
		rd_idx  = (CNT_W'(read_count_q) < total) ? read_count_q : '0;
		rd_last = (CNT_W'(rd_idx) + CNT_W'(1)) == total;
	end

	// Load and read counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			read_count_q <= '0;
		end else if (cmd.load_wr) begin
			load_count_q <= ld_base + CNT_W'(1);
			if (load_count_q >= total) begin
				read_count_q <= '0;
			end
		end else if (cmd.read_issue) begin
			read_count_q <= rd_last ? '0 : rd_idx + ADDR_W'(1);
		end
	end

	// Last-pixel flag of the read in flight.
	always_ff @(posedge clk) begin
		if (cmd.read_issue) begin
			last_q <= rd_last;
		end
	end

	// Seed scan position, kept both as index and as coordinates.
	assign sx_wrap = (DIM_W'(sx_q) + DIM_W'(1)) == eff_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
		end else if (cmd.load_wr || (cmd.clear_step && status.seed_last)) begin
			seed_q <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
		end else if (cmd.clear_step || cmd.seed_next) begin
			seed_q <= seed_q + ADDR_W'(1);
			if (sx_wrap) begin
				sx_q <= '0;
				sy_q <= sy_q + Y_W'(1);
			end else begin
				sx_q <= sx_q + X_W'(1);
			end
		end
	end

	// Queue head, tail and deletion pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			del_q  <= '0;
		end else begin
			if (cmd.seed_push) begin
				head_q <= '0;
				tail_q <= CNT_W'(1);
			end else begin
				if (cmd.pop) begin
					head_q <= head_q + CNT_W'(1);
				end
				if (nb_mark) begin
					tail_q <= tail_q + CNT_W'(1);
				end
			end
			if (cmd.del_start) begin
				del_q <= '0;
			end else if (cmd.del_issue) begin
				del_q <= del_q + CNT_W'(1);
			end
		end
	end

	// Center pixel and neighbor offset counters.
	always_ff @(posedge clk) begin
		if (cmd.latch_center) begin
			cx_q <= que_rdata[X_W-1:0];
			cy_q <= que_rdata[QUEUE_W-1 -: Y_W];
			ix_q <= 2'd0;
			iy_q <= 2'd0;
		end else if (cmd.scan) begin
			if (ix_q == 2'd2) begin
				ix_q <= 2'd0;
				iy_q <= iy_q + 2'd1;
			end else begin
				ix_q <= ix_q + 2'd1;
			end
		end
	end

	// Neighbor coordinates; a step left of column zero wraps high and fails the bound.
	always_comb begin
		tx_full = DIM_W'(cx_q) + DIM_W'(ix_q) - DIM_W'(1);
		ty_full = DIM_W'(cy_q) + DIM_W'(iy_q) - DIM_W'(1);
		nb_ok   = (tx_full < eff_w) && (ty_full < eff_h);
		q_s0    = ADDR_W'(tx_full[X_W-1:0])
			+ ADDR_W'(ty_full[Y_W-1:0]) * ADDR_W'(eff_w);
	end

	// Neighbor pipeline: index, then store read, then test and mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			s1_valid <= cmd.scan && nb_ok;
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		q_s1  <= q_s0;
		tx_s1 <= tx_full[X_W-1:0];
		ty_s1 <= ty_full[Y_W-1:0];
		q_s2  <= q_s1;
		tx_s2 <= tx_s1;
		ty_s2 <= ty_s1;
	end

	assign nb_mark = s2_valid && frm_rdata && !vis_rdata;

	// Deletion pipeline: queue read, then index, then clear the frame bit.
	always_comb begin
		qx      = que_rdata[X_W-1:0];
		qy      = que_rdata[QUEUE_W-1 -: Y_W];
		del_idx = ADDR_W'(qx) + ADDR_W'(qy) * ADDR_W'(eff_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_valid <= 1'b0;
			d2_valid <= 1'b0;
		end else begin
			d1_valid <= cmd.del_issue;
			d2_valid <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_d2 <= del_idx;
	end

	// Frame store ports.
	always_comb begin
		frm_we    = cmd.load_wr || d2_valid;
		frm_waddr = cmd.load_wr ? ld_base[ADDR_W-1:0] : idx_d2;
		frm_wdata = cmd.load_wr ? in_req.edge_in : 1'b0;
		frm_re    = cmd.read_issue || cmd.seed_rd || s1_valid;
		priority if (cmd.read_issue) begin
			frm_raddr = rd_idx;
		end else if (cmd.seed_rd) begin
			frm_raddr = seed_q;
		end else begin
			frm_raddr = q_s1;
		end
	end

	// Visited map ports.
	always_comb begin
		vis_we    = cmd.clear_step || cmd.seed_push || nb_mark;
		vis_waddr = (cmd.clear_step || cmd.seed_push) ? seed_q : q_s2;
		vis_wdata = !cmd.clear_step;
		vis_re    = cmd.seed_rd || s1_valid;
		vis_raddr = cmd.seed_rd ? seed_q : q_s1;
	end

	// Search queue ports; entries hold row and column.
	always_comb begin
		que_we    = cmd.seed_push || nb_mark;
		que_waddr = cmd.seed_push ? '0 : tail_q[ADDR_W-1:0];
		que_wdata = cmd.seed_push ? {sy_q, sx_q} : {ty_s2, tx_s2};
		que_re    = cmd.pop || cmd.del_issue;
		que_raddr = cmd.pop ? head_q[ADDR_W-1:0] : del_q[ADDR_W-1:0];
	end

	scr_ram #(.WIDTH(1), .DEPTH(PIXEL_CAP)) u_frame_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (frm_wdata),
		.re    (frm_re),
		.raddr (frm_raddr),
		.rdata (frm_rdata)
	);

	scr_ram #(.WIDTH(1), .DEPTH(PIXEL_CAP)) u_visited_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.re    (vis_re),
		.raddr (vis_raddr),
		.rdata (vis_rdata)
	);

	scr_ram #(.WIDTH(QUEUE_W), .DEPTH(PIXEL_CAP)) u_queue_ram (
		.clk   (clk),
		.we    (que_we),
		.waddr (que_waddr),
		.wdata (que_wdata),
		.re    (que_re),
		.raddr (que_raddr),
		.rdata (que_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rsp_q.kept_edge  <= frm_rdata;
			out_rsp_q.last_pixel <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// Status to the controller.
	always_comb begin
		status.load_fills  = (ld_base + CNT_W'(1)) == total;
		status.seed_new    = frm_rdata && !vis_rdata;
		status.seed_last   = (CNT_W'(seed_q) + CNT_W'(1)) == total;
		status.queue_empty = head_q == tail_q;
		status.comp_small  = tail_q < CNT_W'(min_size_q);
		status.nb_last     = (ix_q == 2'd2) && (iy_q == 2'd2);
		status.del_done    = del_q == tail_q;
		status.out_free    = !out_valid_q || !out_stall;
	end

	// The neighbor pipeline never reads the visited entry it is marking.
	a_vis_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		vis_we && vis_re |-> vis_waddr != vis_raddr)
		else $error("visited map read and write hit the same entry");

	// The queue head never passes the tail.
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed the tail");

	// A pop waits for the previous neighbor scan to drain.
	a_pop_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !s1_valid && !s2_valid)
		else $error("queue pop while neighbor pipeline busy");

	// A result only enters a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a waiting result");

	// Deletion writes never collide with a pixel load.
	a_frame_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		d2_valid |-> !cmd.load_wr)
		else $error("frame store write collision");

endmodule

FILE: rtl/small_component_remover.sv
// Top level of the small component remover: controller plus datapath.
//
// Requests enter on in_valid / in_stall with an in_req payload. A load request
// stores in_req.edge_in as the next pixel in raster order and gives no result.
// A read request returns one result on out_valid / out_stall: the filtered bit
// of the next pixel and a flag on the frame's final pixel, wrapping after it.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user
// must write them only while idle, which the block itself does not enforce.
//
// A load is taken while idle. A read result passes the frame store's registered
// read port and then enters the output register once that register is free;
// the next request waits until then. The load that completes the frame starts
// the filter: a clearing pass of the visited map, a check of each seed pixel,
// a queue pop plus a nine-step neighbor scan through a three-stage pipeline
// for each pixel of a component, and a deletion pass over each component that
// is removed. No request is taken during the filter. A result that waits under
// out_stall holds in the output register; further loads are still taken, and a
// following read waits until that register frees. Reset restores the register
// defaults and clears the frame counters; the pixel store keeps no reset value.
module small_component_remover import scr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pixel_req_t            in_req,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pixel_rsp_t            out_rsp
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencing.
	scr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_req.opcode),
		.in_stall  (in_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Storage and arithmetic.
	scr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_req    (in_req),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp)
	);

endmodule

FILE: test/small_component_remover_test.sv
// Self-checking testbench of the small component remover with its own area-opening predictor.
`timescale 1ns / 1ps

module small_component_remover_test;
	import scr_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int REQ_TARGET   = 820;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 32;

	// Three by three frame: a lone corner pixel and a diagonal pair.
	localparam logic [8:0] DIRECTED_FRAME = 9'b010100001;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	pixel_req_t            in_req    = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pixel_rsp_t            out_rsp;

	// Requests waiting to be sent and read results still owed by the block.
	pixel_req_t pending_reqs[$];
	pixel_rsp_t expected_pixels[$];

	// Predictor state: registers, frame store, visited map and counters.
	logic [DIM_W-1:0] width_reg    = FRAME_WIDTH_RESET;
	logic [DIM_W-1:0] height_reg   = FRAME_HEIGHT_RESET;
	logic [MIN_W-1:0] min_size_reg = MIN_SIZE_RESET;
	bit               pixel_store [PIXEL_CAP];
	bit               seen_map [PIXEL_CAP];
	int               loaded_cnt   = 0;
	int               read_pos     = 0;

	// Stimulus bookkeeping.
	int gen_loaded = 0;
	int req_total  = 0;
	int error_cnt  = 0;
	int cycle_cnt  = 0;

	// Driver and monitor pacing.
	int gap_left       = 0;
	int burst_left     = 0;
	int drv_roll;
	int hold_left      = 0;
	int free_left      = 0;
	int mon_roll;
	bit long_hold_done = 1'b0;

	small_component_remover i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp)
	);

	// Clock generation.
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Effective frame sizes: zero acts as one, oversize values saturate.
	function automatic int active_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int active_height();
		if (height_reg == 0) return 1;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic int frame_pixels();
		return active_width() * active_height();
	endfunction

	// Breadth-first walk over 8-connected set pixels; clears components below min_size.
	function automatic void prune_components();
		int w, h, total, seed, head, p, q, cx, cy, x0, x1, y0, y1, tx, ty;
		int walk[$];
		w     = active_width();
		h     = active_height();
		total = w * h;
		for (seed = 0; seed < total; seed++) seen_map[seed] = 1'b0;
		for (seed = 0; seed < total; seed++) begin
			if (!seen_map[seed] && pixel_store[seed]) begin
				walk.delete();
				seen_map[seed] = 1'b1;
				walk.push_back(seed);
				head = 0;
				while (head < walk.size()) begin
					p    = walk[head];
					head = head + 1;
					cx   = p % w;
					cy   = p / w;
					x0   = (cx > 0) ? cx - 1 : 0;
					x1   = (cx + 1 < w) ? cx + 1 : w - 1;
					y0   = (cy > 0) ? cy - 1 : 0;
					y1   = (cy + 1 < h) ? cy + 1 : h - 1;
					for (ty = y0; ty <= y1; ty++) begin
						for (tx = x0; tx <= x1; tx++) begin
							q = tx + ty * w;
							if (!seen_map[q] && pixel_store[q]) begin
								seen_map[q] = 1'b1;
								walk.push_back(q);
							end
						end
					end
				end
				if (walk.size() < int'(min_size_reg)) begin
					foreach (walk[k]) pixel_store[walk[k]] = 1'b0;
				end
			end
		end
	endfunction

	// Applies one accepted request to the predictor and records any owed result.
	function automatic void apply_pixel_request(pixel_req_t req);
		int         total, idx;
		pixel_rsp_t want;
		total = frame_pixels();
		if (req.opcode == OP_LOAD) begin
			if (loaded_cnt >= total) begin
				loaded_cnt = 0;
				read_pos   = 0;
			end
			pixel_store[loaded_cnt] = req.edge_in;
			loaded_cnt = loaded_cnt + 1;
			if (loaded_cnt == total) prune_components();
		end else begin
			idx             = (read_pos < total) ? read_pos : 0;
			want.kept_edge  = pixel_store[idx];
			want.last_pixel = (idx + 1 == total);
			read_pos        = (idx + 1 == total) ? 0 : idx + 1;
			expected_pixels.push_back(want);
		end
	endfunction

	// Queues one load request, tracking where the frame stands.
	task automatic queue_load(input bit pix);
		pixel_req_t req;
		if (gen_loaded >= frame_pixels()) gen_loaded = 0;
		gen_loaded     = gen_loaded + 1;
		req.opcode     = OP_LOAD;
		req.edge_in    = pix;
		pending_reqs.push_back(req);
		req_total = req_total + 1;
	endtask

	// Queues read requests; the ignored edge bit is random.
	task automatic queue_reads(input int n);
		pixel_req_t req;
		repeat (n) begin
			req.opcode  = OP_READ;
			req.edge_in = $urandom_range(0, 1);
			pending_reqs.push_back(req);
			req_total = req_total + 1;
		end
	endtask

	// Queues the loads that complete the current frame, at a random density.
	task automatic queue_frame();
		int n, density;
		n       = (gen_loaded >= frame_pixels()) ? frame_pixels() : frame_pixels() - gen_loaded;
		density = $urandom_range(0, 16);
		repeat (n) queue_load($urandom_range(0, 15) < density);
	endtask

	// Writes all three registers on consecutive cycles.
	task automatic write_regs(input int w, input int h, input int m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data  <= w[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data  <= h[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_MIN_SIZE;
		cfg_data  <= m[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		width_reg    = w[DIM_W-1:0];
		height_reg   = h[DIM_W-1:0];
		min_size_reg = m[MIN_W-1:0];
	endtask

	// Waits until every request is taken and every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: sends queued requests with random gaps and gap-free bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req   <= '0;
		end else begin
			if (in_valid && !in_stall) apply_pixel_request(in_req);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					in_req   <= pending_reqs.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left = burst_left - 1;
						gap_left   = 0;
					end else begin
						drv_roll = $urandom_range(0, 99);
						if (drv_roll < 8) burst_left = $urandom_range(20, 80);
						else if (drv_roll < 55) gap_left = 0;
						else if (drv_roll < 85) gap_left = $urandom_range(1, 3);
						else if (drv_roll < 97) gap_left = $urandom_range(4, 10);
						else gap_left = $urandom_range(20, 40);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each read result and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("result with no read request pending");
					error_cnt++;
				end else begin
					if (out_rsp.kept_edge !== expected_pixels[0].kept_edge) begin
						$error("kept_edge: expected %0b, got %0b",
							expected_pixels[0].kept_edge, out_rsp.kept_edge);
						error_cnt++;
					end
					if (out_rsp.last_pixel !== expected_pixels[0].last_pixel) begin
						$error("last_pixel: expected %0b, got %0b",
							expected_pixels[0].last_pixel, out_rsp.last_pixel);
						error_cnt++;
					end
					void'(expected_pixels.pop_front());
				end
				// Hold off once for a long time so the output fills and the input stalls.
				if (!long_hold_done) begin
					long_hold_done = 1'b1;
					hold_left      = LONG_HOLD;
				end
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (free_left > 0) begin
				free_left = free_left - 1;
				out_stall <= 1'b0;
			end else begin
				mon_roll = $urandom_range(0, 99);
				if (mon_roll < 60) begin
					if (mon_roll < 10) free_left = $urandom_range(20, 80);
					out_stall <= 1'b0;
				end else begin
					if (mon_roll < 90) hold_left = $urandom_range(0, 2);
					else if (mon_roll < 98) hold_left = $urandom_range(3, 10);
					else hold_left = $urandom_range(20, 60);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus: a directed frame, then random phases of register settings and frames.
	initial begin
		int i, phase_idx, w, h, m, pick, nframes;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Lone pixel is removed, diagonal pair is kept; reads wrap past the last pixel.
		write_regs(3, 3, 2);
		for (i = 0; i < 9; i++) queue_load(DIRECTED_FRAME[i]);
		queue_reads(10);
		wait_drained();

		// Width of zero acts as one; the read position now lies beyond the total.
		write_regs(0, 1, 2);
		queue_reads(2);
		// A load after a complete frame starts a new one; its lone pixel is too small.
		queue_load(1'b1);
		queue_reads(1);

		phase_idx = 0;
		while (req_total < REQ_TARGET) begin
			wait_drained();
			if (gen_loaded >= frame_pixels() && $urandom_range(0, 4) == 0) begin
				// Shrink the frame and keep reading what is stored.
				w = $urandom_range(0, active_width());
				h = $urandom_range(0, active_height());
				write_regs(w, h, int'(min_size_reg));
				queue_reads($urandom_range(1, frame_pixels() + 3));
			end else begin
				pick = $urandom_range(0, 9);
				if (phase_idx == 3) begin
					w = $urandom_range(256, 511);
					h = $urandom_range(0, 1);
				end else if (phase_idx == 8) begin
					w = $urandom_range(0, 1);
					h = $urandom_range(256, 511);
				end else if (pick == 0) begin
					w = $urandom_range(13, 64);
					h = $urandom_range(1, 3);
				end else begin
					w = $urandom_range(0, 12);
					h = $urandom_range(0, 12);
				end
				case ($urandom_range(0, 9))
					0:       m = 0;
					1:       m = 1;
					2:       m = 65536;
					3:       m = 131071;
					4:       m = $urandom_range(0, 131071);
					default: m = $urandom_range(2, 12);
				endcase
				write_regs(w, h, m);
				nframes = (frame_pixels() > 64) ? 1 : $urandom_range(1, 3);
				repeat (nframes) begin
					queue_frame();
					if (frame_pixels() > 64) queue_reads($urandom_range(1, 8));
					else queue_reads($urandom_range(1, frame_pixels() + 3));
				end
			end
			phase_idx = phase_idx + 1;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() != 0) begin
			$error("%0d read results never arrived", expected_pixels.size());
			error_cnt++;
		end
		if (error_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
